FILE: sv/hrp_pkg.sv
// Shared types, codes and helper functions for the HTTP request head parser.
// Used by the parse engine, the result queue and the top level; no dependencies.
package hrp_pkg;

    localparam int LINE_LIMIT_DEF   = 1024;
    localparam int HEADER_LIMIT_DEF = 32;

    // Result queue geometry.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // Field kinds.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_URI     = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_KEY     = 3'd4;
    localparam logic [2:0] KIND_VALUE   = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_LONG      = 3'd1;
    localparam logic [2:0] ERR_NO_SP1    = 3'd2;
    localparam logic [2:0] ERR_NO_SP2    = 3'd3;
    localparam logic [2:0] ERR_VERSION   = 3'd4;
    localparam logic [2:0] ERR_HDR_COUNT = 3'd5;
    localparam logic [2:0] ERR_NO_COLON  = 3'd6;

    // Line part codes.
    localparam logic [1:0] PART_FIRST  = 2'd0;
    localparam logic [1:0] PART_SECOND = 2'd1;
    localparam logic [1:0] PART_THIRD  = 2'd2;

    // Version prefix match progress.
    localparam logic [2:0] VM_FULL = 3'd5;
    localparam logic [2:0] VM_BAD  = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] field_kind;
        logic [9:0] field_offset;
        logic       line_end;
        logic [5:0] header_index;
        logic [9:0] trimmed_length;
        logic [1:0] status;
        logic [2:0] error_code;
        logic       last;
    } hrp_result_t;

    // Space, TAB, LF, VT, FF and CR count as whitespace.
    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Expected character of the "HTTP/" prefix at a given match position.
    function automatic logic [7:0] ver_char(logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: sv/hrp_engine.sv
// Parse engine: the running line state and the logic that turns one input word
// into one or two result words. Depends on hrp_pkg.
module hrp_engine #(
    parameter int LINE_LIMIT   = hrp_pkg::LINE_LIMIT_DEF,
    parameter int HEADER_LIMIT = hrp_pkg::HEADER_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                clear,
    input  logic [7:0]          in_byte,
    output hrp_pkg::hrp_result_t res0,
    output hrp_pkg::hrp_result_t res1,
    output logic                two
);

    localparam int LL_W = $clog2(LINE_LIMIT);
    localparam int HT_W = $clog2(HEADER_LIMIT + 1);

    localparam logic [1:0] PH_REQ  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_ERR  = 2'd3;

    localparam logic [LL_W-1:0] LL_MAX = LL_W'(LINE_LIMIT - 1);
    localparam logic [HT_W-1:0] HT_MAX = HT_W'(HEADER_LIMIT);

    typedef struct packed {
        logic [1:0]      part;
        logic [LL_W-1:0] off;
        logic [2:0]      vm;
        logic [LL_W-1:0] lne;
    } ctx_t;

    typedef struct packed {
        ctx_t            ctx;
        logic            valid;
        logic [2:0]      kind;
        logic [LL_W-1:0] off;
    } cres_t;

    logic [1:0]      phase_reg, phase_next;
    logic [LL_W-1:0] ll_reg, ll_next;
    logic            pend_reg, pend_next;
    ctx_t            ctx_reg, ctx_next;
    logic [HT_W-1:0] ht_reg, ht_next;
    logic [2:0]      err_reg, err_next;

    logic [LL_W-1:0] ll_inc;
    logic            hdr;
    cres_t           c0, c1;

    function automatic cres_t do_content(ctx_t s, logic in_hdr, logic [7:0] c);
        cres_t r;
        r.ctx   = s;
        r.valid = 1'b0;
        r.kind  = hrp_pkg::KIND_NONE;
        r.off   = '0;
        if (!in_hdr)
        begin
            if (s.part != hrp_pkg::PART_THIRD && c == hrp_pkg::CH_SPACE)
            begin
                r.ctx.part = s.part + 2'd1;
                r.ctx.off  = '0;
                r.ctx.vm   = 3'd0;
            end
            else
            begin
                r.valid   = 1'b1;
                r.off     = s.off;
                r.ctx.off = s.off + 1'b1;
                case (s.part)
                    hrp_pkg::PART_FIRST:  r.kind = hrp_pkg::KIND_METHOD;
                    hrp_pkg::PART_SECOND: r.kind = hrp_pkg::KIND_URI;
                    default:              r.kind = hrp_pkg::KIND_VERSION;
                endcase
                if (s.part == hrp_pkg::PART_THIRD && s.vm < hrp_pkg::VM_FULL)
                begin
                    r.ctx.vm = (c == hrp_pkg::ver_char(s.vm)) ? s.vm + 3'd1
                                                              : hrp_pkg::VM_BAD;
                end
            end
        end
        else if (s.part == hrp_pkg::PART_FIRST)
        begin
            if (c == hrp_pkg::CH_COLON)
            begin
                r.ctx.part = hrp_pkg::PART_SECOND;
                r.ctx.off  = '0;
                r.ctx.lne  = '0;
            end
            else
            begin
                r.valid   = 1'b1;
                r.kind    = hrp_pkg::KIND_KEY;
                r.off     = s.off;
                r.ctx.off = s.off + 1'b1;
            end
        end
        else if (!(s.part == hrp_pkg::PART_SECOND && hrp_pkg::is_ws(c)))
        begin
            // Leading whitespace of a value is dropped; anything after it counts.
            r.ctx.part = hrp_pkg::PART_THIRD;
            r.valid    = 1'b1;
            r.kind     = hrp_pkg::KIND_VALUE;
            r.off      = s.off;
            r.ctx.off  = s.off + 1'b1;
            if (!hrp_pkg::is_ws(c))
            begin
                r.ctx.lne = s.off + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [1:0] status_of(logic [1:0] ph);
        logic [1:0] st;
        unique case (ph)
            PH_DONE: st = hrp_pkg::ST_DONE;
            PH_ERR:  st = hrp_pkg::ST_ERROR;
            default: st = hrp_pkg::ST_BUSY;
        endcase
        return st;
    endfunction

    function automatic hrp_pkg::hrp_result_t content_word(cres_t r, logic [7:0] c,
                                                          logic [5:0] hi);
        hrp_pkg::hrp_result_t w;
        w                = '0;
        w.out_byte       = r.valid ? c : 8'h00;
        w.byte_valid     = r.valid;
        w.field_kind     = r.kind;
        w.field_offset   = 10'(r.off);
        w.header_index   = hi;
        w.status         = hrp_pkg::ST_BUSY;
        w.error_code     = hrp_pkg::ERR_NONE;
        return w;
    endfunction

    assign ll_inc = ll_reg + 1'b1;
    assign hdr    = (phase_reg == PH_HDR);
    assign c0     = do_content(ctx_reg, hdr, pend_reg ? hrp_pkg::CH_CR : in_byte);
    assign c1     = do_content(c0.ctx, hdr, in_byte);

    always_comb
    begin
        phase_next = phase_reg;
        ll_next    = ll_reg;
        pend_next  = pend_reg;
        ctx_next   = ctx_reg;
        ht_next    = ht_reg;
        err_next   = err_reg;
        res0       = '0;
        res1       = '0;
        two        = 1'b0;

        if (clear)
        begin
            phase_next = PH_REQ;
            ll_next    = '0;
            pend_next  = 1'b0;
            ctx_next   = '0;
            ht_next    = '0;
            err_next   = hrp_pkg::ERR_NONE;
        end
        else if (phase_reg == PH_DONE || phase_reg == PH_ERR)
        begin
            res0.header_index = 6'(ht_reg);
            res0.status       = status_of(phase_reg);
            res0.error_code   = err_reg;
        end
        else if (ll_reg == LL_MAX)
        begin
            // Counts even the LF of a CR LF pair.
            phase_next        = PH_ERR;
            err_next          = hrp_pkg::ERR_LONG;
            pend_next         = 1'b0;
            res0.header_index = 6'(ht_reg);
            res0.status       = hrp_pkg::ST_ERROR;
            res0.error_code   = hrp_pkg::ERR_LONG;
        end
        else
        begin
            ll_next = ll_inc;
            if (in_byte == hrp_pkg::CH_LF && pend_reg)
            begin
                pend_next = 1'b0;
                ll_next   = '0;
                ctx_next  = '0;
                if (!hdr)
                begin
                    if (ctx_reg.part == hrp_pkg::PART_FIRST)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hrp_pkg::ERR_NO_SP1;
                    end
                    else if (ctx_reg.part == hrp_pkg::PART_SECOND)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hrp_pkg::ERR_NO_SP2;
                    end
                    else if (ctx_reg.vm != hrp_pkg::VM_FULL)
                    begin
                        phase_next = PH_ERR;
                        err_next   = hrp_pkg::ERR_VERSION;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                    end
                end
                else if (ll_inc == LL_W'(2))
                begin
                    // Empty header line closes the head.
                    phase_next = PH_DONE;
                end
                else if (ht_reg >= HT_MAX)
                begin
                    phase_next = PH_ERR;
                    err_next   = hrp_pkg::ERR_HDR_COUNT;
                end
                else if (ctx_reg.part == hrp_pkg::PART_FIRST)
                begin
                    phase_next = PH_ERR;
                    err_next   = hrp_pkg::ERR_NO_COLON;
                end
                else
                begin
                    res0.trimmed_length = 10'(ctx_reg.lne);
                    ht_next             = ht_reg + 1'b1;
                end
                res0.line_end     = 1'b1;
                res0.header_index = 6'(ht_reg);
                res0.status       = status_of(phase_next);
                res0.error_code   = err_next;
            end
            else if (in_byte == hrp_pkg::CH_CR)
            begin
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    ctx_next = c0.ctx;
                    res0     = content_word(c0, hrp_pkg::CH_CR, 6'(ht_reg));
                end
                else
                begin
                    res0.header_index = 6'(ht_reg);
                    res0.status       = hrp_pkg::ST_BUSY;
                    res0.error_code   = err_reg;
                end
            end
            else if (pend_reg)
            begin
                // The held CR turns out to be content and goes out first.
                pend_next = 1'b0;
                ctx_next  = c1.ctx;
                res0      = content_word(c0, hrp_pkg::CH_CR, 6'(ht_reg));
                res1      = content_word(c1, in_byte, 6'(ht_reg));
                two       = 1'b1;
            end
            else
            begin
                ctx_next = c0.ctx;
                res0     = content_word(c0, in_byte, 6'(ht_reg));
            end
        end
        res0.last = !two;
        res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_REQ;
            ll_reg    <= '0;
            pend_reg  <= 1'b0;
            ctx_reg   <= '0;
            ht_reg    <= '0;
            err_reg   <= hrp_pkg::ERR_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            ll_reg    <= ll_next;
            pend_reg  <= pend_next;
            ctx_reg   <= ctx_next;
            ht_reg    <= ht_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: sv/hrp_result_fifo.sv
// Small result queue that takes one or two result words per cycle when written and
// hands out one per cycle when read. Depends on hrp_pkg.
module hrp_result_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_two,
    input  hrp_pkg::hrp_result_t          wr_data0,
    input  hrp_pkg::hrp_result_t          wr_data1,
    input  logic                          rd_en,
    output hrp_pkg::hrp_result_t          rd_data,
    output logic [hrp_pkg::RES_CNT_W-1:0] count
);

    hrp_pkg::hrp_result_t mem [hrp_pkg::RES_DEPTH];

    logic [hrp_pkg::RES_PTR_W-1:0] wp_reg, wp_next;
    logic [hrp_pkg::RES_PTR_W-1:0] rp_reg, rp_next;
    logic [hrp_pkg::RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic [hrp_pkg::RES_CNT_W-1:0] wr_n;

    assign wr_n    = wr_en ? (wr_two ? hrp_pkg::RES_CNT_W'(2) : hrp_pkg::RES_CNT_W'(1))
                           : '0;
    assign wp_next = wp_reg + hrp_pkg::RES_PTR_W'(wr_n);
    assign rp_next = rp_reg + hrp_pkg::RES_PTR_W'(rd_en);
    assign cnt_next = cnt_reg + wr_n - hrp_pkg::RES_CNT_W'(rd_en);

    assign rd_data = mem[rp_reg];
    assign count   = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data0;
            if (wr_two)
            begin
                mem[wp_reg + 1'b1] <= wr_data1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/http_request_head_parser.sv
// HTTP request head parser: an input register and a four-entry result queue around the engine.
// One input word per cycle is accepted while the input register is empty or the queue
// holds two words or fewer; a word whose held CR turns out to be content yields two result
// words, handed out one at a time, registered in the queue once the engine takes the word.
// rst_n clears the parse state to the start of a request line; no clearing pass.
// Depends on hrp_pkg, hrp_engine and hrp_result_fifo.
module http_request_head_parser #(
    parameter int LINE_LIMIT   = hrp_pkg::LINE_LIMIT_DEF,
    parameter int HEADER_LIMIT = hrp_pkg::HEADER_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       clear_request,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [2:0] field_kind,
    output logic [9:0] field_offset,
    output logic       line_end,
    output logic [5:0] header_index,
    output logic [9:0] trimmed_length,
    output logic [1:0] status,
    output logic [2:0] error_code,
    output logic       last
);

    logic       full_reg, full_next;
    logic [7:0] byte_reg;
    logic       clear_reg;
    logic       accept;
    logic       room;
    logic       consume;
    logic       pop;
    logic       two;

    hrp_pkg::hrp_result_t          res0, res1, head;
    logic [hrp_pkg::RES_CNT_W-1:0] fifo_count;

    // Room for the worst case of two words from the held item.
    assign room      = (fifo_count <= hrp_pkg::RES_CNT_W'(hrp_pkg::RES_DEPTH - 2));
    assign consume   = full_reg && room;
    assign in_stall  = full_reg && !room;
    assign accept    = in_valid && !in_stall;
    assign full_next = accept ? 1'b1 : (consume ? 1'b0 : full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= in_byte;
            clear_reg <= clear_request;
        end
    end

    hrp_engine #(
        .LINE_LIMIT   (LINE_LIMIT),
        .HEADER_LIMIT (HEADER_LIMIT)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (consume),
        .clear   (clear_reg),
        .in_byte (byte_reg),
        .res0    (res0),
        .res1    (res1),
        .two     (two)
    );

    hrp_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (consume),
        .wr_two   (two),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .rd_en    (pop),
        .rd_data  (head),
        .count    (fifo_count)
    );

    assign out_valid      = (fifo_count != '0);
    assign pop            = out_valid && !out_stall;
    assign out_byte       = head.out_byte;
    assign byte_valid     = head.byte_valid;
    assign field_kind     = head.field_kind;
    assign field_offset   = head.field_offset;
    assign line_end       = head.line_end;
    assign header_index   = head.header_index;
    assign trimmed_length = head.trimmed_length;
    assign status         = head.status;
    assign error_code     = head.error_code;
    assign last           = head.last;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= hrp_pkg::RES_CNT_W'(hrp_pkg::RES_DEPTH))
        else $error("result queue count exceeds its depth");

    a_consume_lands: assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> (fifo_count != '0))
        else $error("consumed word produced no queued result");

    a_content_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (status == hrp_pkg::ST_BUSY && !line_end))
        else $error("content word carries a final status or a line end");

    a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && two) |-> (!res0.last && res1.last))
        else $error("paired results are not marked correctly");

endmodule

FILE: sim/http_request_head_parser_test.sv
// Testbench for http_request_head_parser: an in-bench parse model predicts every result
// word, which is checked field by field against the block. Needs hrp_pkg and the RTL.
`timescale 1ns / 100ps

module http_request_head_parser_test;

    localparam int LINE_MAX    = hrp_pkg::LINE_LIMIT_DEF;
    localparam int HDR_MAX     = hrp_pkg::HEADER_LIMIT_DEF;
    localparam int ITEM_TARGET = 1650;

    localparam logic [7:0]  TAB_CHAR    = 8'h09;
    localparam logic [2:0]  VM_START    = 3'd0;
    localparam logic [39:0] VERSION_TAG = "HTTP/";

    typedef enum logic [1:0] {PH_REQUEST, PH_HEADERS, PH_FINISHED, PH_FAILED} parse_phase_t;
    typedef enum int {FLAW_NONE, FLAW_NO_SP1, FLAW_NO_SP2, FLAW_VERSION, FLAW_NO_COLON}
        request_flaw_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       clear_request;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] field_kind;
    logic [9:0] field_offset;
    logic       line_end;
    logic [5:0] header_index;
    logic [9:0] trimmed_length;
    logic [1:0] status;
    logic [2:0] error_code;
    logic       last;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int mismatches    = 0;

    // Parse model state.
    parse_phase_t ph;
    int unsigned  line_bytes;
    int unsigned  part_off;
    int unsigned  value_end;
    int unsigned  hdr_count;
    logic         cr_held;
    logic [1:0]   part;
    logic [2:0]   ver_seen;
    logic [2:0]   fail_code;

    hrp_pkg::hrp_result_t step_words[$];
    hrp_pkg::hrp_result_t due_words[$];

    http_request_head_parser #(
        .LINE_LIMIT   (LINE_MAX),
        .HEADER_LIMIT (HDR_MAX)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .clear_request  (clear_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_kind     (field_kind),
        .field_offset   (field_offset),
        .line_end       (line_end),
        .header_index   (header_index),
        .trimmed_length (trimmed_length),
        .status         (status),
        .error_code     (error_code),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // ---------------------------------------------------------------- parse model

    function automatic logic blank_char(logic [7:0] c);
        return c == hrp_pkg::CH_SPACE || (c >= TAB_CHAR && c <= hrp_pkg::CH_CR);
    endfunction

    function automatic void reset_parser();
        ph         = PH_REQUEST;
        line_bytes = 0;
        part_off   = 0;
        value_end  = 0;
        hdr_count  = 0;
        cr_held    = 1'b0;
        part       = hrp_pkg::PART_FIRST;
        ver_seen   = VM_START;
        fail_code  = hrp_pkg::ERR_NONE;
    endfunction

    function automatic void mark_failed(logic [2:0] code);
        ph        = PH_FAILED;
        fail_code = code;
    endfunction

    function automatic hrp_pkg::hrp_result_t make_word(logic [7:0] c, logic valid,
                                                       logic [2:0] kind, logic [9:0] off,
                                                       logic lend, logic [9:0] trim);
        hrp_pkg::hrp_result_t w;
        w.out_byte       = valid ? c : 8'h00;
        w.byte_valid     = valid;
        w.field_kind     = kind;
        w.field_offset   = off;
        w.line_end       = lend;
        w.header_index   = hdr_count[5:0];
        w.trimmed_length = trim;
        w.status         = (ph == PH_FINISHED) ? hrp_pkg::ST_DONE
                         : (ph == PH_FAILED) ? hrp_pkg::ST_ERROR : hrp_pkg::ST_BUSY;
        w.error_code     = fail_code;
        w.last           = 1'b0;
        return w;
    endfunction

    function automatic void push_empty_word();
        step_words.push_back(make_word(8'h00, 1'b0, hrp_pkg::KIND_NONE, 10'd0, 1'b0, 10'd0));
    endfunction

    // One content byte, already counted in the line length.
    function automatic void take_content(logic [7:0] c);
        logic       valid;
        logic [2:0] kind;
        logic [9:0] off;
        valid = 1'b0;
        kind  = hrp_pkg::KIND_NONE;
        off   = 10'd0;
        if (ph == PH_REQUEST)
        begin
            if (part != hrp_pkg::PART_THIRD && c == hrp_pkg::CH_SPACE)
            begin
                part     = part + 2'd1;
                part_off = 0;
                ver_seen = VM_START;
            end
            else
            begin
                valid = 1'b1;
                kind  = (part == hrp_pkg::PART_FIRST) ? hrp_pkg::KIND_METHOD
                      : (part == hrp_pkg::PART_SECOND) ? hrp_pkg::KIND_URI
                      : hrp_pkg::KIND_VERSION;
                off   = part_off[9:0];
                part_off++;
                if (part == hrp_pkg::PART_THIRD && ver_seen < hrp_pkg::VM_FULL)
                    ver_seen = (c == VERSION_TAG[39 - 8 * ver_seen -: 8])
                             ? ver_seen + 3'd1 : hrp_pkg::VM_BAD;
            end
        end
        else if (part == hrp_pkg::PART_FIRST)
        begin
            if (c == hrp_pkg::CH_COLON)
            begin
                part      = hrp_pkg::PART_SECOND;
                part_off  = 0;
                value_end = 0;
            end
            else
            begin
                valid = 1'b1;
                kind  = hrp_pkg::KIND_KEY;
                off   = part_off[9:0];
                part_off++;
            end
        end
        else if (!(part == hrp_pkg::PART_SECOND && blank_char(c)))
        begin
            // Leading whitespace of a value is dropped; anything after it is kept.
            part  = hrp_pkg::PART_THIRD;
            valid = 1'b1;
            kind  = hrp_pkg::KIND_VALUE;
            off   = part_off[9:0];
            part_off++;
            if (!blank_char(c))
                value_end = part_off;
        end
        step_words.push_back(make_word(c, valid, kind, off, 1'b0, 10'd0));
    endfunction

    function automatic void close_line();
        logic [5:0]           idx;
        logic [9:0]           trim;
        hrp_pkg::hrp_result_t w;
        idx     = hdr_count[5:0];
        trim    = 10'd0;
        cr_held = 1'b0;
        if (ph == PH_REQUEST)
        begin
            if (part == hrp_pkg::PART_FIRST)
                mark_failed(hrp_pkg::ERR_NO_SP1);
            else if (part == hrp_pkg::PART_SECOND)
                mark_failed(hrp_pkg::ERR_NO_SP2);
            else if (ver_seen != hrp_pkg::VM_FULL)
                mark_failed(hrp_pkg::ERR_VERSION);
            else
                ph = PH_HEADERS;
        end
        else if (line_bytes == 2)
            ph = PH_FINISHED;
        else if (hdr_count >= HDR_MAX)
            mark_failed(hrp_pkg::ERR_HDR_COUNT);
        else if (part == hrp_pkg::PART_FIRST)
            mark_failed(hrp_pkg::ERR_NO_COLON);
        else
        begin
            trim = value_end[9:0];
            hdr_count++;
        end
        line_bytes = 0;
        part       = hrp_pkg::PART_FIRST;
        ver_seen   = VM_START;
        part_off   = 0;
        value_end  = 0;
        w = make_word(8'h00, 1'b0, hrp_pkg::KIND_NONE, 10'd0, 1'b1, trim);
        w.header_index = idx;
        step_words.push_back(w);
    endfunction

    // Works out the result words of one accepted input word and queues them.
    function automatic void parse_byte(logic [7:0] c, logic clr);
        step_words.delete();
        if (clr)
        begin
            reset_parser();
            push_empty_word();
        end
        else if (ph == PH_FINISHED || ph == PH_FAILED)
            push_empty_word();
        else if (line_bytes >= LINE_MAX - 1)
        begin
            cr_held = 1'b0;
            mark_failed(hrp_pkg::ERR_LONG);
            push_empty_word();
        end
        else
        begin
            line_bytes++;
            if (c == hrp_pkg::CH_LF && cr_held)
                close_line();
            else if (c == hrp_pkg::CH_CR)
            begin
                // A CR is held until the next byte tells whether it ends the line.
                if (cr_held)
                    take_content(hrp_pkg::CH_CR);
                else
                    push_empty_word();
                cr_held = 1'b1;
            end
            else
            begin
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    take_content(hrp_pkg::CH_CR);
                end
                take_content(c);
            end
        end
        step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            due_words.push_back(step_words[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        hrp_pkg::hrp_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_words.size() == 0)
            begin
                $error("Result word with nothing expected: out_byte %0d, field_kind %0d",
                       out_byte, field_kind);
                mismatches++;
            end
            else
            begin
                want = due_words.pop_front();
                check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
                check_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
                check_field("field_kind", 16'(want.field_kind), 16'(field_kind));
                check_field("field_offset", 16'(want.field_offset), 16'(field_offset));
                check_field("line_end", 16'(want.line_end), 16'(line_end));
                check_field("header_index", 16'(want.header_index), 16'(header_index));
                check_field("trimmed_length", 16'(want.trimmed_length),
                            16'(trimmed_length));
                check_field("status", 16'(want.status), 16'(status));
                check_field("error_code", 16'(want.error_code), 16'(error_code));
                check_field("last", 16'(want.last), 16'(last));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Valid stays high after an accept; the next call either keeps it or idles.
    task automatic send_word(input logic [7:0] c, input logic clr);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= c;
        clear_request <= clr;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        items_sent++;
        parse_byte(c, clr);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_line_end();
        send_word(hrp_pkg::CH_CR, 1'b0);
        send_word(hrp_pkg::CH_LF, 1'b0);
    endtask

    function automatic logic [7:0] field_char(logic no_space, logic no_colon);
        logic [7:0] c;
        do
        begin
            if ($urandom_range(9) != 0)
                c = 8'($urandom_range(126, 33));
            else
                c = 8'($urandom_range(255));
        end
        while (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF
               || (no_space && c == hrp_pkg::CH_SPACE)
               || (no_colon && c == hrp_pkg::CH_COLON));
        return c;
    endfunction

    function automatic logic [7:0] blank_pick();
        case ($urandom_range(3)) inside
            0, 1:    return hrp_pkg::CH_SPACE;
            2:       return TAB_CHAR;
            default: return 8'($urandom_range(12, 11));
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(9)) inside
            0, 1, 2: return hrp_pkg::CH_CR;
            3:       return hrp_pkg::CH_LF;
            4:       return hrp_pkg::CH_SPACE;
            5:       return hrp_pkg::CH_COLON;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A stray CR now and then must come back out as content.
    task automatic send_field(input int len, input logic no_space, input logic no_colon);
        repeat (len)
        begin
            if ($urandom_range(19) == 0)
                send_word(hrp_pkg::CH_CR, 1'b0);
            send_word(field_char(no_space, no_colon), 1'b0);
        end
    endtask

    task automatic send_random_request();
        int            style;
        int            n_hdr;
        request_flaw_t flaw;
        string         ver;
        send_word(8'($urandom_range(255)), 1'b1);
        style = $urandom_range(99);
        if (style < 12)
        begin
            repeat ($urandom_range(40, 1))
                send_word(noise_char(), $urandom_range(29) == 0);
            return;
        end
        flaw = (style < 30) ? request_flaw_t'($urandom_range(FLAW_NO_COLON, FLAW_NO_SP1))
                            : FLAW_NONE;
        send_field($urandom_range(6, 1), 1'b1, 1'b0);
        if (flaw != FLAW_NO_SP1)
            send_word(hrp_pkg::CH_SPACE, 1'b0);
        send_field($urandom_range(12, 1), 1'b1, 1'b0);
        if (flaw != FLAW_NO_SP2)
            send_word(hrp_pkg::CH_SPACE, 1'b0);
        ver = "HTTP/1.1";
        if (flaw == FLAW_VERSION)
        begin
            if ($urandom_range(3) == 0)
                ver = "";
            else
                ver.putc($urandom_range(4), field_char(1'b1, 1'b0));
        end
        send_text(ver);
        send_line_end();
        n_hdr = $urandom_range(4, (flaw == FLAW_NO_COLON) ? 1 : 0);
        for (int i = 0; i < n_hdr; i++)
        begin
            send_field($urandom_range(8, 1), 1'b0, 1'b1);
            if (!(flaw == FLAW_NO_COLON && i == n_hdr - 1))
                send_word(hrp_pkg::CH_COLON, 1'b0);
            repeat ($urandom_range(2))
                send_word(blank_pick(), 1'b0);
            send_field($urandom_range(10), 1'b0, 1'b0);
            repeat ($urandom_range(2))
                send_word(blank_pick(), 1'b0);
            send_line_end();
        end
        send_line_end();
        repeat ($urandom_range(2))
            send_word(field_char(1'b0, 1'b0), 1'b0);
    endtask

    // ---------------------------------------------------------------- tests

    // Zero and all-ones bytes, separators, a stray CR as key content, a CR CR LF
    // ending, the empty line that finishes the head, and a byte ignored afterwards.
    task automatic test_directed_request();
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(hrp_pkg::CH_SPACE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(hrp_pkg::CH_SPACE, 1'b0);
        send_text("HTTP/");
        send_line_end();
        send_word(hrp_pkg::CH_CR, 1'b0);
        send_word("k", 1'b0);
        send_word(hrp_pkg::CH_COLON, 1'b0);
        send_word(hrp_pkg::CH_SPACE, 1'b0);
        send_word("v", 1'b0);
        send_word(hrp_pkg::CH_CR, 1'b0);
        send_line_end();
        send_line_end();
        send_word("x", 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // The LF of a CR LF that arrives at the length limit still fails the parse.
    task automatic test_line_limit();
        send_word(8'h00, 1'b1);
        repeat (LINE_MAX - 2)
            send_word("A", 1'b0);
        send_line_end();
        send_word("A", 1'b0);
    endtask

    task automatic test_header_limit();
        send_word(8'h00, 1'b1);
        send_text("GET / HTTP/1.1");
        send_line_end();
        repeat (HDR_MAX + 1)
        begin
            send_text("k:v");
            send_line_end();
        end
        send_word("z", 1'b0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int goal);
        int  start;
        logic paused;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start         = items_sent;
        paused        = 1'b0;
        while (items_sent - start < goal)
        begin
            send_random_request();
            if (!paused && items_sent - start >= goal / 2)
            begin
                // Let the block run empty before the rest of the phase.
                wait_for_results();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        int phase_goal;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;
        clear_request <= 1'b0;
        rst_n         <= 1'b0;
        reset_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_request();
        test_line_limit();
        test_header_limit();
        // The random phases share what is left of the word budget.
        phase_goal = (ITEM_TARGET - items_sent) / 4;
        test_random_traffic(0, 0, phase_goal);
        test_random_traffic(78, 0, phase_goal);
        test_random_traffic(0, 78, phase_goal);
        test_random_traffic(13, 13, phase_goal);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/hrp_pkg.sv
sv/hrp_engine.sv
sv/hrp_result_fifo.sv
sv/http_request_head_parser.sv
sim/http_request_head_parser_test.sv
